FILE: rtl/power_transition_consent_table_macros.svh
// Assertion macros for the power transition consent table.
// Used by the checker module; no other dependencies.
`ifndef POWER_TRANSITION_CONSENT_TABLE_MACROS_SVH
`define POWER_TRANSITION_CONSENT_TABLE_MACROS_SVH
// Implication checked every clock, off during reset.
`define PTC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, off during reset.
`define PTC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/ptc_pkg.sv
// Package for the power transition consent table: codes, row type, helpers.
// No dependencies.
`default_nettype none
package ptc_pkg;
  localparam int AgentSlotsDefault = 8;

  typedef enum logic [3:0] {
    CMD_POLL = 4'd0, CMD_FORGET = 4'd1, CMD_DECLARE = 4'd2, CMD_BEGIN = 4'd3,
    CMD_REPLY = 4'd4, CMD_SETTLED = 4'd5, CMD_COMMIT = 4'd6, CMD_CANCEL = 4'd7,
    CMD_FITQ = 4'd8, CMD_FULLQ = 4'd9
  } cmd_t;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_PERM = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_BUSY = 3'd4;
  localparam logic [2:0] ST_NOENT = 3'd5;

  localparam logic [1:0] FIT_ASK = 2'd0;
  localparam logic [1:0] FIT_ANY = 2'd1;
  localparam logic [1:0] FIT_FULL_ONLY = 2'd2;
  localparam logic [1:0] ANS_NONE = 2'd0;
  localparam logic [1:0] ANS_OK = 2'd1;
  localparam logic [1:0] ANS_PARKED = 2'd2;

  localparam logic [1:0] REG_CPU_MAX = 2'd0;
  localparam logic [1:0] REG_LISTEN = 2'd1;
  localparam logic [1:0] REG_KPID = 2'd2;

  // One agent row; the answer lives in a separate epoch-tagged field.
  typedef struct packed {
    logic        used;
    logic [7:0]  pid;
    logic        polled;
    logic [31:0] last_poll;
    logic [1:0]  fitness;
  } row_t;

  // Control from sequencer to table memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  function automatic logic time_reached(logic [31:0] now, logic [31:0] when_t);
    logic [31:0] d;
    d = now - when_t;
    return ~d[31];
  endfunction
endpackage
`default_nettype wire

FILE: rtl/power_transition_consent_table.sv
// Top level: command sequencer that walks the agent table memory.
// Depends on ptc_pkg and ptc_table_mem.
//
// Channel   Direction  Handshake          Payload
// command   in         start & !busy      cmd, pid, now_ms, begin/declare/reply fields
// result    out        done (one cycle)   status, flag, current/pending target, grace
// config    in         cfg_we             cfg_index, cfg_data
//
// An item walks every table row, one row read per cycle through the memory's
// single read port, then goes through S_ACT to S_DONE, which raises done;
// the next item is taken at the earliest at the edge that ends the done cycle,
// so a new item is never taken while the last one is still in flight.
// Reset clears all rows through a write pass in S_CLEAR; busy is high
// meanwhile. An accepted begin writes every row back with no answer during its
// scan and flips an epoch bit. The result is shown for one cycle and cannot be stalled.
`default_nettype none
module power_transition_consent_table import ptc_pkg::*; #(
  parameter int AGENT_SLOTS = AgentSlotsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [3:0]  cmd,
  input  wire logic [7:0]  pid,
  input  wire logic [31:0] now_ms,
  input  wire logic [1:0]  fitness_code,
  input  wire logic [1:0]  answer_code,
  input  wire logic        cause,
  input  wire logic [31:0] grace_time,
  input  wire logic [2:0]  want_mode,
  input  wire logic        want_display_on,
  input  wire logic [9:0]  want_min_mhz,
  input  wire logic [9:0]  want_max_mhz,
  output logic [2:0]       status,
  output logic             flag,
  output logic [2:0]       mode,
  output logic             cur_cause,
  output logic             display_on,
  output logic [9:0]       cur_min_mhz,
  output logic [9:0]       cur_max_mhz,
  output logic [2:0]       pending_mode,
  output logic             pending_display_on,
  output logic [9:0]       pending_min_mhz,
  output logic [9:0]       pending_max_mhz,
  output logic [31:0]      grace_left_ms
);
  localparam int AW = (AGENT_SLOTS > 1) ? $clog2(AGENT_SLOTS) : 1;
  localparam int CW = $clog2(AGENT_SLOTS + 1);
  localparam logic [CW-1:0] LAST = CW'(AGENT_SLOTS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001, S_IDLE = 5'b00010, S_SCAN = 5'b00100,
    S_ACT = 5'b01000, S_DONE = 5'b10000
  } state_t;

  state_t state;
  logic [CW-1:0] rd_cnt, chk_cnt;
  logic chk_valid;

  // Configuration and target registers
  logic [31:0] listen_win;
  logic [7:0]  kpid;
  logic [2:0]  c_mode, w_mode;
  logic        c_scr, w_scr;
  logic [9:0]  c_min, c_max, w_min, w_max;
  logic        pending, lcause, epoch;
  logic [31:0] begin_t, dead_t;

  // Latched command
  cmd_t        q_cmd;
  logic [3:0]  q_raw;
  logic [7:0]  q_pid;
  logic [31:0] q_now, q_grace;
  logic [1:0]  q_fit, q_ans;
  logic        q_cause, q_wscr;
  logic [2:0]  q_wmode;
  logic [9:0]  q_wmin, q_wmax;

  // Scan results
  logic          hit, free_found, unsettled, fullonly;
  logic [AW-1:0] hit_idx, free_idx;
  row_t          hit_row;
  logic [1:0]    hit_ans;

  mem_ctl_t   mctl;
  logic [AW-1:0] rd_addr, wr_addr;
  row_t       rd_row, wr_row;
  logic [1:0] rd_ans, wr_ans;
  logic       rd_epoch;

  ptc_table_mem #(.AGENT_SLOTS(AGENT_SLOTS)) u_mem (
    .clk(clk), .ctl(mctl), .rd_addr(rd_addr), .wr_addr(wr_addr),
    .wr_row(wr_row), .wr_ans(wr_ans), .wr_epoch(epoch),
    .rd_row(rd_row), .rd_ans(rd_ans), .rd_epoch(rd_epoch)
  );

  // Row view after answer epoch check
  logic [1:0] row_ans;
  logic       row_listen;
  assign row_ans = (rd_epoch == epoch) ? rd_ans : ANS_NONE;
  assign row_listen = rd_row.polled && ((begin_t - rd_row.last_poll) <= listen_win);

  // Command decisions from the scan
  logic valid_cmd, do_write, enter_ok, begin_ok;
  logic [2:0] st;
  logic fl;
  logic [AW-1:0] tgt;
  always_comb begin
    valid_cmd = (q_raw <= 4'(CMD_FULLQ));
    begin_ok  = valid_cmd && (q_cmd == CMD_BEGIN) && (q_wmin != '0) &&
                (q_wmax >= q_wmin) && !pending;
    enter_ok  = (q_pid != kpid) && (hit || free_found);
    tgt       = hit ? hit_idx : free_idx;
    st        = ST_OK;
    fl        = 1'b0;
    do_write  = 1'b0;
    wr_row    = hit ? hit_row : '0;
    wr_row.used = 1'b1;
    wr_row.pid  = q_pid;
    wr_ans    = hit ? hit_ans : ANS_NONE;
    if (!valid_cmd) begin
      st = ST_INVALID;
    end else begin
      case (q_cmd)
        CMD_POLL: begin
          do_write = enter_ok;
          wr_row.polled = 1'b1;
          wr_row.last_poll = q_now;
        end
        CMD_FORGET: begin
          do_write = hit;
          wr_row = '0;
          wr_ans = ANS_NONE;
        end
        CMD_DECLARE: begin
          if (q_pid == kpid) st = ST_PERM;
          else if (q_fit > FIT_FULL_ONLY) st = ST_INVALID;
          else if (!enter_ok) st = ST_FULL;
          else begin
            do_write = 1'b1;
            wr_row.fitness = q_fit;
          end
        end
        CMD_BEGIN: begin
          if (q_wmin == '0 || q_wmax < q_wmin) st = ST_INVALID;
          else if (pending) st = ST_BUSY;
        end
        CMD_REPLY: begin
          if (!pending) st = ST_NOENT;
          else if (q_ans == ANS_NONE) st = ST_INVALID;
          else if (!enter_ok) st = ST_FULL;
          else begin
            do_write = 1'b1;
            wr_ans = q_ans;
          end
        end
        CMD_SETTLED: fl = !pending || !unsettled || time_reached(q_now, dead_t);
        CMD_COMMIT: if (!pending) st = ST_NOENT;
        CMD_FITQ: fl = hit && (hit_row.fitness == FIT_ANY || hit_ans == ANS_OK ||
                               hit_ans == ANS_PARKED);
        CMD_FULLQ: fl = fullonly;
        default: st = ST_OK;
      endcase
    end
    // Begin scan writes the row just read back with no answer
    if (state == S_SCAN) begin
      wr_row = rd_row;
      wr_ans = ANS_NONE;
    end
    // Reset pass writes empty rows
    if (state == S_CLEAR) begin
      wr_row = '0;
      wr_ans = ANS_NONE;
    end
  end

  // Memory control
  always_comb begin
    mctl.rd_en = (state == S_SCAN);
    mctl.wr_en = (state == S_CLEAR) || ((state == S_ACT) && do_write) ||
                 ((state == S_SCAN) && chk_valid && begin_ok);
    rd_addr = rd_cnt[AW-1:0];
    wr_addr = (state == S_CLEAR) ? rd_cnt[AW-1:0] :
              (state == S_SCAN) ? chk_cnt[AW-1:0] : tgt;
  end

  assign busy = (state != S_IDLE);

  // Sequencer, scan and state update
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      rd_cnt <= '0;
      chk_valid <= 1'b0;
      listen_win <= 32'd2000;
      kpid <= '0;
      c_mode <= '0; c_scr <= 1'b1; c_min <= 10'd240; c_max <= 10'd240;
      w_mode <= '0; w_scr <= 1'b0; w_min <= '0; w_max <= '0;
      pending <= 1'b0; lcause <= 1'b0; epoch <= 1'b0;
      begin_t <= '0; dead_t <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CPU_MAX: begin
            c_mode <= '0; c_scr <= 1'b1;
            c_min <= (cfg_data[9:0] == '0) ? 10'd1 : cfg_data[9:0];
            c_max <= (cfg_data[9:0] == '0) ? 10'd1 : cfg_data[9:0];
          end
          REG_LISTEN: listen_win <= cfg_data;
          REG_KPID: kpid <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: begin
          rd_cnt <= rd_cnt + 1'b1;
          if (rd_cnt == LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            q_cmd <= cmd_t'(cmd); q_raw <= cmd; q_pid <= pid; q_now <= now_ms;
            q_fit <= fitness_code; q_ans <= answer_code; q_cause <= cause;
            q_grace <= grace_time; q_wmode <= want_mode; q_wscr <= want_display_on;
            q_wmin <= want_min_mhz; q_wmax <= want_max_mhz;
            rd_cnt <= '0; chk_valid <= 1'b0;
            hit <= 1'b0; free_found <= 1'b0; unsettled <= 1'b0; fullonly <= 1'b0;
            hit_idx <= '0; free_idx <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          chk_valid <= (rd_cnt != CW'(AGENT_SLOTS));
          chk_cnt <= rd_cnt;
          if (rd_cnt != CW'(AGENT_SLOTS)) rd_cnt <= rd_cnt + 1'b1;
          // examine row read last cycle
          if (chk_valid) begin
            if (rd_row.used && rd_row.pid == q_pid && !hit) begin
              hit <= 1'b1; hit_idx <= chk_cnt[AW-1:0];
              hit_row <= rd_row; hit_ans <= row_ans;
            end
            if (!rd_row.used && !free_found) begin
              free_found <= 1'b1; free_idx <= chk_cnt[AW-1:0];
            end
            if (rd_row.used && rd_row.fitness == FIT_ASK && row_listen &&
                row_ans == ANS_NONE) unsettled <= 1'b1;
            if (rd_row.used && rd_row.fitness == FIT_FULL_ONLY) fullonly <= 1'b1;
          end
          if (!chk_valid && rd_cnt == CW'(AGENT_SLOTS)) state <= S_ACT;
        end
        S_ACT: begin
          status <= st;
          flag <= fl;
          if (valid_cmd) begin
            if (q_cmd == CMD_BEGIN && st == ST_OK) begin
              w_mode <= q_wmode; w_scr <= q_wscr; w_min <= q_wmin; w_max <= q_wmax;
              lcause <= q_cause; pending <= 1'b1; begin_t <= q_now;
              dead_t <= q_now + q_grace; epoch <= ~epoch;
            end
            if (q_cmd == CMD_COMMIT && st == ST_OK) begin
              c_mode <= w_mode; c_scr <= w_scr; c_min <= w_min; c_max <= w_max;
              pending <= 1'b0;
            end
            if (q_cmd == CMD_CANCEL) pending <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Status view, valid while done is high
  always_comb begin
    mode = c_mode; cur_cause = lcause; display_on = c_scr;
    cur_min_mhz = c_min; cur_max_mhz = c_max;
    pending_mode = pending ? w_mode : c_mode;
    pending_display_on = pending ? w_scr : c_scr;
    pending_min_mhz = pending ? w_min : c_min;
    pending_max_mhz = pending ? w_max : c_max;
    grace_left_ms = (pending && !time_reached(q_now, dead_t)) ? (dead_t - q_now) : '0;
  end
endmodule
`default_nettype wire

FILE: rtl/ptc_table_mem.sv
// Agent table memory: one write port, one registered read port.
// Depends on ptc_pkg.
`default_nettype none
module ptc_table_mem import ptc_pkg::*; #(
  parameter int AGENT_SLOTS = AgentSlotsDefault,
  localparam int AW = (AGENT_SLOTS > 1) ? $clog2(AGENT_SLOTS) : 1
) (
  input  wire logic          clk,
  input  wire mem_ctl_t      ctl,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic [AW-1:0] wr_addr,
  input  wire row_t          wr_row,
  input  wire logic [1:0]    wr_ans,
  input  wire logic          wr_epoch,
  output row_t               rd_row,
  output logic [1:0]         rd_ans,
  output logic               rd_epoch
);
  row_t       rows  [AGENT_SLOTS];
  logic [1:0] ans   [AGENT_SLOTS];
  logic       epoch [AGENT_SLOTS];

  // Write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      rows[wr_addr]  <= wr_row;
      ans[wr_addr]   <= wr_ans;
      epoch[wr_addr] <= wr_epoch;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_row   <= rows[rd_addr];
      rd_ans   <= ans[rd_addr];
      rd_epoch <= epoch[rd_addr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ptc_checker.sv
// Port-level checker for the power transition consent table, with bind.
// Depends on ptc_pkg and the macros header.
`default_nettype none
`include "power_transition_consent_table_macros.svh"
module ptc_checker import ptc_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [2:0] status,
  input wire logic [9:0] pending_min_mhz,
  input wire logic [9:0] pending_max_mhz
);
  `PTC_ASSERT_NXT(a_busy_after_start, clk, rst, start && !busy, busy, "not busy after start")
  `PTC_ASSERT_IMP(a_done_busy, clk, rst, done, busy == 1'b0, "done while busy")
  `PTC_ASSERT_IMP(a_status_range, clk, rst, done, status <= ST_NOENT, "bad status")
  `PTC_ASSERT_NXT(a_done_pulse, clk, rst, done, !done, "done held")
  `PTC_ASSERT_IMP(a_pend_order, clk, rst, done && pending_min_mhz != 10'd0, pending_max_mhz >= pending_min_mhz, "pending max below min")
endmodule

bind power_transition_consent_table ptc_checker u_ptc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .status(status),
  .pending_min_mhz(pending_min_mhz), .pending_max_mhz(pending_max_mhz)
);
`default_nettype wire
